// ===== src/aafc_pkg.sv =====
// ----------------------------------------------------------------------------
// aafc_pkg - shared types and constants
// Operation codes, sequencer states, field widths and the distance unit's
// control and result groups for the aging address filter.
// ----------------------------------------------------------------------------
package aafc_pkg;

    // Field widths
    localparam int ADDR_W     = 24;
    localparam int ENTRY_W    = 25;              // valid bit over address
    localparam int DIST_W     = 5;
    localparam int COUNT_O_W  = 11;
    localparam int OUT_W      = 48;

    // Golden-ratio multiplier for the home slot
    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

    // Register reset value and the "nothing yet" distance
    localparam logic [DIST_W-1:0] MAX_BITS_RST = 5'd2;
    localparam logic [DIST_W-1:0] DIST_NONE    = 5'd25;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_TEST    = 2'd1,
        OP_EXPIRE  = 2'd2,
        OP_CORRECT = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_SCAN,
        ST_SCAN_END,
        ST_DONE
    } state_t;

    // Sequencer to distance unit
    typedef struct packed {
        logic start;    // clear the running best
        logic check;    // entry on the bus is to be compared
    } dist_ctl_t;

    // Distance unit to sequencer
    typedef struct packed {
        logic              unique_hit;
        logic [ADDR_W-1:0] addr;
        logic [DIST_W-1:0] distance;
    } dist_res_t;

endpackage

// ===== src/aafc_ram.sv =====
// ----------------------------------------------------------------------------
// aafc_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents not reset.
// ----------------------------------------------------------------------------
module aafc_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/aafc_dist.sv =====
// ----------------------------------------------------------------------------
// aafc_dist - Hamming distance and best-match tracker
// Compares one stored entry per cycle against the syndrome and keeps the
// closest nonzero distance within the limit, flagging distinct ties.
// ----------------------------------------------------------------------------
module aafc_dist (
    input  logic                                clk,
    input  logic                                rst_n,
    input  aafc_pkg::dist_ctl_t                 ctl,
    input  logic [aafc_pkg::ENTRY_W-1:0]        entry,
    input  logic [aafc_pkg::ADDR_W-1:0]         syndrome,
    input  logic [aafc_pkg::DIST_W-1:0]         limit,
    output aafc_pkg::dist_res_t                 res
);

    logic [aafc_pkg::DIST_W-1:0] best_d_reg, best_d_next;
    logic [aafc_pkg::ADDR_W-1:0] best_a_reg, best_a_next;
    logic                        amb_reg, amb_next;

    logic [aafc_pkg::ADDR_W-1:0] ent_addr;
    logic [aafc_pkg::DIST_W-1:0] ham_d;
    logic                        qual;

    // Distance of the current entry and whether it may compete
    assign ent_addr = entry[aafc_pkg::ADDR_W-1:0];
    assign ham_d    = aafc_pkg::DIST_W'($countones(ent_addr ^ syndrome));
    assign qual     = ctl.check && entry[aafc_pkg::ENTRY_W-1] &&
                      (ham_d != '0) && (ham_d <= limit);

    // Running best update
    always_comb
    begin
        best_d_next = best_d_reg;
        best_a_next = best_a_reg;
        amb_next    = amb_reg;
        priority if (ctl.start)
        begin
            best_d_next = aafc_pkg::DIST_NONE;
            best_a_next = '0;
            amb_next    = 1'b0;
        end
        else if (qual && (ham_d < best_d_reg))
        begin
            best_d_next = ham_d;
            best_a_next = ent_addr;
            amb_next    = 1'b0;
        end
        else if (qual && (ham_d == best_d_reg) && (ent_addr != best_a_reg))
        begin
            amb_next = 1'b1;
        end
        else
        begin
            amb_next = amb_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_d_reg <= aafc_pkg::DIST_NONE;
            best_a_reg <= '0;
            amb_reg    <= 1'b0;
        end
        else
        begin
            best_d_reg <= best_d_next;
            best_a_reg <= best_a_next;
            amb_reg    <= amb_next;
        end
    end

    // A winner of zero never counts
    assign res.unique_hit = (best_a_reg != '0) && !amb_reg;
    assign res.addr       = best_a_reg;
    assign res.distance   = best_d_reg;

endmodule

// ===== src/aging_address_filter_with_correction_top.sv =====
// ----------------------------------------------------------------------------
// aging_address_filter_with_correction_top - two-table aging address set
// Linear-probing hash set in two RAMs with add, test, expire and a
// correcting test that scans both tables through one distance unit.
// ----------------------------------------------------------------------------
// Steps per item: add and test probe from the home slot; expire walks the
// whole inactive table; correct probes and, without an exact hit, scans
// both tables through the distance unit.
// One item at a time: input is ready again once the result loads.
// A finished result waits in the output register while the next item runs.
// After reset both tables are swept empty; no item is taken
// meanwhile, configuration writes are. max_correct_bits resets to 2.
// ----------------------------------------------------------------------------
module aging_address_filter_with_correction_top #(
    parameter int TABLE_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] address
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [0] found, [24:1] matched_address,
                                        // [29:25] bit_errors,
                                        // [30] table_full,
                                        // [41:31] active_count, [47:42] zero
    // max_correct_bits register
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data
);

    localparam int DEPTH = 1 << TABLE_BITS;
    localparam int CNT_W = TABLE_BITS + 1;
    localparam int AW    = aafc_pkg::ADDR_W;
    localparam int EW    = aafc_pkg::ENTRY_W;
    localparam int DW    = aafc_pkg::DIST_W;

    aafc_pkg::state_t state_reg, state_next;
    aafc_pkg::op_t    op_reg, op_next;

    logic [AW-1:0]         addr_reg, addr_next;
    logic [TABLE_BITS-1:0] idx_reg, idx_next;
    logic [TABLE_BITS-1:0] steps_reg, steps_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  act_sel_reg, act_sel_next;
    logic                  srch0_reg, srch0_next;
    logic                  srch1_reg, srch1_next;
    logic                  hit_reg, hit_next;
    logic                  full_reg, full_next;
    logic                  scan_tab_reg, scan_tab_next;
    logic                  scan_vld_reg;
    logic                  scan_tab_d_reg;
    logic [DW-1:0]         max_bits_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [47:0]           m_data_reg, m_data_next;

    logic                  we0, we1;
    logic [EW-1:0]         wdata;
    logic [EW-1:0]         rdata0, rdata1;
    logic [31:0]           hash_prod;

    aafc_pkg::dist_ctl_t   dctl;
    aafc_pkg::dist_res_t   dres;

    logic                  v0, v1, stop0, stop1, hit_any, probe_last;
    logic                  add_wr, idx_last, out_free;
    logic                  res_found;
    logic [AW-1:0]         res_match;
    logic [DW-1:0]         res_bits;
    logic [CNT_W+10:0]     cnt_ext;

    // Table RAMs, both read at the current slot every cycle
    aafc_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_tab0 (
        .clk   (clk),
        .we    (we0),
        .waddr (idx_reg),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rdata0)
    );

    aafc_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_tab1 (
        .clk   (clk),
        .we    (we1),
        .waddr (idx_reg),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rdata1)
    );

    // Shared distance unit for the correction scan
    aafc_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (dctl),
        .entry    (scan_tab_d_reg ? rdata1 : rdata0),
        .syndrome (addr_reg),
        .limit    (max_bits_reg),
        .res      (dres)
    );

    // Home slot: top bits of the 32-bit product
    assign hash_prod = {8'd0, addr_reg} * aafc_pkg::HASH_MULT;

    // Probe slot decode
    assign v0         = rdata0[EW-1];
    assign v1         = rdata1[EW-1];
    assign stop0      = !v0 || (rdata0[AW-1:0] == addr_reg);
    assign stop1      = !v1 || (rdata1[AW-1:0] == addr_reg);
    assign hit_any    = (srch0_reg && v0 && (rdata0[AW-1:0] == addr_reg)) ||
                        (srch1_reg && v1 && (rdata1[AW-1:0] == addr_reg));
    assign probe_last = (steps_reg == '1);
    assign idx_last   = (idx_reg == '1);
    assign add_wr     = (state_reg == aafc_pkg::ST_PROBE_CHK) &&
                        (op_reg == aafc_pkg::OP_ADD) &&
                        (act_sel_reg ? (srch1_reg && !v1) : (srch0_reg && !v0));
    assign out_free   = !m_valid_reg || m_axis_tready;

    // Table writes: reset sweep, expire wipe, add store
    assign wdata = add_wr ? {1'b1, addr_reg} : '0;
    assign we0   = (state_reg == aafc_pkg::ST_CLEAR) ||
                   ((op_reg == aafc_pkg::OP_EXPIRE) && act_sel_reg &&
                    (state_reg == aafc_pkg::ST_SCAN)) ||
                   (add_wr && !act_sel_reg);
    assign we1   = (state_reg == aafc_pkg::ST_CLEAR) ||
                   ((op_reg == aafc_pkg::OP_EXPIRE) && !act_sel_reg &&
                    (state_reg == aafc_pkg::ST_SCAN)) ||
                   (add_wr && act_sel_reg);

    // Result fields
    always_comb
    begin
        res_found = 1'b0;
        res_match = '0;
        res_bits  = '0;
        unique case (op_reg)
            aafc_pkg::OP_ADD,
            aafc_pkg::OP_EXPIRE:
            begin
                res_found = 1'b0;
            end
            aafc_pkg::OP_TEST:
            begin
                res_found = hit_reg;
                res_match = hit_reg ? addr_reg : '0;
            end
            aafc_pkg::OP_CORRECT:
            begin
                if (hit_reg)
                begin
                    res_found = (addr_reg != '0);
                    res_match = addr_reg;
                end
                else if (dres.unique_hit)
                begin
                    res_found = 1'b1;
                    res_match = dres.addr;
                    res_bits  = dres.distance;
                end
            end
            default:
            begin
                res_found = 1'b0;
            end
        endcase
    end

    assign cnt_ext = {11'd0, count_reg};

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        addr_next     = addr_reg;
        idx_next      = idx_reg;
        steps_next    = steps_reg;
        count_next    = count_reg;
        act_sel_next  = act_sel_reg;
        srch0_next    = srch0_reg;
        srch1_next    = srch1_reg;
        hit_next      = hit_reg;
        full_next     = full_reg;
        scan_tab_next = scan_tab_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;
        s_axis_tready = 1'b0;
        dctl.start    = 1'b0;
        dctl.check    = scan_vld_reg;

        unique case (state_reg)
            aafc_pkg::ST_CLEAR:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_last)
                begin
                    state_next = aafc_pkg::ST_IDLE;
                end
            end
            aafc_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    op_next   = aafc_pkg::op_t'(s_axis_tuser);
                    addr_next = s_axis_tdata;
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    full_next = 1'b0;
                    if (aafc_pkg::op_t'(s_axis_tuser) == aafc_pkg::OP_EXPIRE)
                    begin
                        // Wipe reuses the scan walk over the inactive table
                        state_next = aafc_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = aafc_pkg::ST_HASH;
                    end
                end
            end
            aafc_pkg::ST_HASH:
            begin
                idx_next   = hash_prod[31 -: TABLE_BITS];
                steps_next = '0;
                hit_next   = 1'b0;
                full_next  = 1'b0;
                if (op_reg == aafc_pkg::OP_ADD)
                begin
                    srch0_next = !act_sel_reg;
                    srch1_next = act_sel_reg;
                end
                else
                begin
                    srch0_next = 1'b1;
                    srch1_next = 1'b1;
                end
                state_next = aafc_pkg::ST_PROBE_RD;
            end
            aafc_pkg::ST_PROBE_RD:
            begin
                state_next = aafc_pkg::ST_PROBE_CHK;
            end
            aafc_pkg::ST_PROBE_CHK:
            begin
                hit_next   = hit_reg || hit_any;
                srch0_next = srch0_reg && !stop0 && !hit_any && !probe_last;
                srch1_next = srch1_reg && !stop1 && !hit_any && !probe_last;
                if (add_wr)
                begin
                    count_next = count_reg + 1'b1;
                end
                // Whole active table walked with no hit and no empty slot
                if ((op_reg == aafc_pkg::OP_ADD) && probe_last &&
                    ((srch0_reg && !stop0) || (srch1_reg && !stop1)))
                begin
                    full_next = 1'b1;
                end
                if (srch0_next || srch1_next)
                begin
                    idx_next   = idx_reg + 1'b1;
                    steps_next = steps_reg + 1'b1;
                    state_next = aafc_pkg::ST_PROBE_RD;
                end
                else if ((op_reg == aafc_pkg::OP_CORRECT) && !hit_next)
                begin
                    idx_next      = '0;
                    scan_tab_next = 1'b0;
                    dctl.start    = 1'b1;
                    state_next    = aafc_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = aafc_pkg::ST_DONE;
                end
            end
            aafc_pkg::ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_last)
                begin
                    if (op_reg == aafc_pkg::OP_EXPIRE)
                    begin
                        act_sel_next = !act_sel_reg;
                        count_next   = '0;
                        state_next   = aafc_pkg::ST_DONE;
                    end
                    else if (!scan_tab_reg)
                    begin
                        scan_tab_next = 1'b1;
                    end
                    else
                    begin
                        state_next = aafc_pkg::ST_SCAN_END;
                    end
                end
            end
            aafc_pkg::ST_SCAN_END:
            begin
                // last entry is compared in this cycle
                state_next = aafc_pkg::ST_DONE;
            end
            aafc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, cnt_ext[10:0], full_reg, res_bits,
                                    res_match, res_found};
                    state_next   = aafc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aafc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= aafc_pkg::ST_CLEAR;
            op_reg         <= aafc_pkg::OP_ADD;
            idx_reg        <= '0;
            steps_reg      <= '0;
            count_reg      <= '0;
            act_sel_reg    <= 1'b0;
            srch0_reg      <= 1'b0;
            srch1_reg      <= 1'b0;
            hit_reg        <= 1'b0;
            full_reg       <= 1'b0;
            scan_tab_reg   <= 1'b0;
            scan_vld_reg   <= 1'b0;
            scan_tab_d_reg <= 1'b0;
            max_bits_reg   <= aafc_pkg::MAX_BITS_RST;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            idx_reg        <= idx_next;
            steps_reg      <= steps_next;
            count_reg      <= count_next;
            act_sel_reg    <= act_sel_next;
            srch0_reg      <= srch0_next;
            srch1_reg      <= srch1_next;
            hit_reg        <= hit_next;
            full_reg       <= full_next;
            scan_tab_reg   <= scan_tab_next;
            scan_vld_reg   <= (state_reg == aafc_pkg::ST_SCAN) &&
                              (op_reg == aafc_pkg::OP_CORRECT);
            scan_tab_d_reg <= scan_tab_reg;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en)
            begin
                max_bits_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Occupancy never exceeds the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("occupancy count above table size");

    // Both tables are written together only by the reset sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        (we0 && we1) |-> (state_reg == aafc_pkg::ST_CLEAR))
        else $error("both tables written outside reset sweep");

    // A result is loaded only from the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> ($past(state_reg) == aafc_pkg::ST_DONE))
        else $error("result loaded outside done state");

    // Full is raised only by an add
    assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (op_reg == aafc_pkg::OP_ADD))
        else $error("table full flagged for a non-add item");

endmodule

// ===== verif/tb_aging_address_filter_with_correction_top.sv =====
// ----------------------------------------------------------------------------
// tb_aging_address_filter_with_correction_top - self-checking bench
// Streams add, test, expire and correcting-test items into the two-table
// address filter, with random idle bursts on both sides of the stream and
// one long output stall. A scoreboard keeps its own copy of both hash
// tables and the correction search and checks every result item field by
// field. Phases step max_correct_bits through 2, 24, 0, 1, 3, 31 and a
// random value, and one phase loads the active table with distinct adds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_aging_address_filter_with_correction_top;

    localparam int SLOT_BITS = 10;
    localparam int SLOTS     = 1 << SLOT_BITS;
    localparam int POOL_MAX  = 48;
    localparam int FILL_N    = 40;

    typedef struct {
        aafc_pkg::op_t op;
        logic [23:0]   addr;
    } filter_item_t;

    typedef struct packed {
        logic        found;
        logic [23:0] matched;
        logic [4:0]  bits;
        logic        full;
        logic [10:0] count;
    } filter_result_t;

    // DUT connections
    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [4:0]  cfg_wr_data = '0;

    // Stimulus and scoreboard state
    filter_item_t   item_feed[$];
    filter_result_t awaited_results[$];
    logic [23:0]    recent_addrs[$];
    logic [23:0]    fill_addrs[$];
    bit             fill_taken[logic [23:0]];
    int             mismatch_count = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int             send_gap;
    int             recv_gap;
    int             hold_left;
    logic           hold_arm = 1'b0;
    logic           hold_used;

    // Scoreboard copy of the filter: [24] valid, [23:0] address
    logic [24:0]    shadow_tbl [0:1][0:SLOTS-1];
    int             act_sel = 0;
    int             occ = 0;
    logic [4:0]     limit_bits = aafc_pkg::MAX_BITS_RST;

    aging_address_filter_with_correction_top #(
        .TABLE_BITS(SLOT_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scoreboard model
    // ------------------------------------------------------------------
    function automatic int home_of(logic [23:0] a);
        logic [31:0] prod;
        prod = {8'd0, a} * aafc_pkg::HASH_MULT;
        return int'(prod[31:32-SLOT_BITS]);
    endfunction

    // slot holding a, else first empty slot, else -1
    function automatic int find_slot(int t, logic [23:0] a);
        int h0;
        int h;
        h0 = home_of(a);
        h  = h0;
        do
        begin
            if (!shadow_tbl[t][h][24] || shadow_tbl[t][h][23:0] == a)
                return h;
            h = (h + 1) % SLOTS;
        end
        while (h != h0);
        return -1;
    endfunction

    function automatic bit holds(int t, logic [23:0] a);
        int s;
        s = find_slot(t, a);
        return s >= 0 && shadow_tbl[t][s][24];
    endfunction

    task automatic compute_filter_result(aafc_pkg::op_t op, logic [23:0] a);
        filter_result_t res;
        int          slot;
        int          best_d;
        int          cnt;
        int          d;
        logic [23:0] best_a;
        logic [23:0] cand;
        res = '0;
        case (op)
            aafc_pkg::OP_ADD:
            begin
                slot = find_slot(act_sel, a);
                if (slot < 0)
                    res.full = 1'b1;
                else if (!shadow_tbl[act_sel][slot][24])
                begin
                    shadow_tbl[act_sel][slot] = {1'b1, a};
                    occ++;
                end
            end
            aafc_pkg::OP_TEST:
            begin
                if (holds(0, a) || holds(1, a))
                begin
                    res.found   = 1'b1;
                    res.matched = a;
                end
            end
            aafc_pkg::OP_EXPIRE:
            begin
                for (int i = 0; i < SLOTS; i++)
                    shadow_tbl[1-act_sel][i] = '0;
                act_sel = 1 - act_sel;
                occ     = 0;
            end
            default:
            begin
                if (holds(0, a) || holds(1, a))
                begin
                    // exact hit; address zero never reports found
                    if (a != 24'd0)
                    begin
                        res.found   = 1'b1;
                        res.matched = a;
                    end
                end
                else
                begin
                    best_d = 25;
                    best_a = '0;
                    cnt    = 0;
                    for (int t = 0; t < 2; t++)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (shadow_tbl[t][i][24])
                            begin
                                cand = shadow_tbl[t][i][23:0];
                                d    = $countones(a ^ cand);
                                if (d != 0 && d <= int'(limit_bits))
                                begin
                                    if (d < best_d)
                                    begin
                                        best_d = d;
                                        best_a = cand;
                                        cnt    = 1;
                                    end
                                    else if (d == best_d && cand != best_a)
                                        cnt++;
                                end
                            end
                        end
                    end
                    // ties between distinct addresses and a zero winner fail
                    if (best_a != 24'd0 && cnt == 1)
                    begin
                        res.found   = 1'b1;
                        res.matched = best_a;
                        res.bits    = best_d[4:0];
                    end
                end
            end
        endcase
        res.count = occ[10:0];
        awaited_results.push_back(res);
    endtask

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatch_count++;
        $display("mismatch: %s got %0h expected %0h", what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Input driver: pops the item feed, predicts on each accepted item
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        filter_item_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            send_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                compute_filter_result(aafc_pkg::op_t'(s_axis_tuser), s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap      <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (item_feed.size() != 0 && $urandom_range(0, 99) < send_idle_pct)
                begin
                    send_gap      <= $urandom_range(0, 9);
                    s_axis_tvalid <= 1'b0;
                end
                else if (item_feed.size() != 0)
                begin
                    nxt = item_feed.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.addr;
                    s_axis_tuser  <= nxt.op;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long output stall, armed once from the sequence
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_arm && !hold_used)
        begin
            hold_left <= 400;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Output ready with random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
        end
        else if (hold_left != 0)
            m_axis_tready <= 1'b0;
        else if (recv_gap != 0)
        begin
            recv_gap      <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < recv_idle_pct)
        begin
            recv_gap      <= $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Result monitor
    always @(posedge clk)
    begin
        filter_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_results.size() == 0)
                report_mismatch("result item with nothing awaited", m_axis_tdata[31:0], 0);
            else
            begin
                want = awaited_results.pop_front();
                if (m_axis_tdata[0] !== want.found)
                    report_mismatch("found", 32'(m_axis_tdata[0]), 32'(want.found));
                if (m_axis_tdata[24:1] !== want.matched)
                    report_mismatch("matched_address", 32'(m_axis_tdata[24:1]),
                                    32'(want.matched));
                if (m_axis_tdata[29:25] !== want.bits)
                    report_mismatch("bit_errors", 32'(m_axis_tdata[29:25]),
                                    32'(want.bits));
                if (m_axis_tdata[30] !== want.full)
                    report_mismatch("table_full", 32'(m_axis_tdata[30]), 32'(want.full));
                if (m_axis_tdata[41:31] !== want.count)
                    report_mismatch("active_count", 32'(m_axis_tdata[41:31]),
                                    32'(want.count));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------
    task automatic push_item(aafc_pkg::op_t op, logic [23:0] a);
        filter_item_t it;
        it.op   = op;
        it.addr = a;
        item_feed.push_back(it);
        if (op == aafc_pkg::OP_ADD)
        begin
            recent_addrs.push_back(a);
            if (recent_addrs.size() > POOL_MAX)
                void'(recent_addrs.pop_front());
        end
    endtask

    task automatic wait_all_done();
        @(negedge clk);
        while (item_feed.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_limit(logic [4:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        limit_bits  = v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [23:0] flip_bits(logic [23:0] a, int k);
        logic [23:0] r;
        r = a;
        for (int i = 0; i < k; i++)
            r[$urandom_range(0, 23)] ^= 1'b1;
        return r;
    endfunction

    function automatic logic [23:0] rand_addr();
        case ($urandom_range(0, 7))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom_range(0, 255));
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [23:0] pick_known();
        if (recent_addrs.size() == 0)
            return rand_addr();
        return recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
    endfunction

    // Random mix of adds, tests, correcting tests and occasional expires, many around stored addresses
    task automatic queue_random_items(int n);
        int r;
        int s;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            s = $urandom_range(0, 99);
            if (r < 36)
            begin
                if (s < 55)
                    push_item(aafc_pkg::OP_ADD, rand_addr());
                else if (s < 85)
                    push_item(aafc_pkg::OP_ADD,
                              flip_bits(pick_known(), $urandom_range(1, 2)));
                else
                    push_item(aafc_pkg::OP_ADD, pick_known());
            end
            else if (r < 62)
                push_item(aafc_pkg::OP_TEST, (s < 50) ? pick_known() : rand_addr());
            else if (r < 97)
            begin
                if (s < 20)
                    push_item(aafc_pkg::OP_CORRECT, pick_known());
                else if (s < 80)
                    push_item(aafc_pkg::OP_CORRECT,
                              flip_bits(pick_known(), $urandom_range(1, 4)));
                else if (s < 90)
                    push_item(aafc_pkg::OP_CORRECT, rand_addr());
                else
                    push_item(aafc_pkg::OP_CORRECT, 24'($urandom_range(0, 3)));
            end
            else
                push_item(aafc_pkg::OP_EXPIRE, rand_addr());
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [23:0] a;
        for (int t = 0; t < 2; t++)
            for (int i = 0; i < SLOTS; i++)
                shadow_tbl[t][i] = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero address, extremes, duplicate, tie, aging
        send_idle_pct <= 20;
        recv_idle_pct <= 20;
        push_item(aafc_pkg::OP_TEST,    24'h000000);
        push_item(aafc_pkg::OP_CORRECT, 24'h000000);
        push_item(aafc_pkg::OP_ADD,     24'h000000);
        push_item(aafc_pkg::OP_TEST,    24'h000000);
        push_item(aafc_pkg::OP_CORRECT, 24'h000000);   // exact hit on zero
        push_item(aafc_pkg::OP_CORRECT, 24'h000001);   // winner would be zero
        push_item(aafc_pkg::OP_ADD,     24'hFFFFFF);
        push_item(aafc_pkg::OP_TEST,    24'hFFFFFF);
        push_item(aafc_pkg::OP_CORRECT, 24'hFFFFFE);   // unique, one bit
        push_item(aafc_pkg::OP_ADD,     24'h123456);
        push_item(aafc_pkg::OP_ADD,     24'h123456);   // already present
        push_item(aafc_pkg::OP_ADD,     24'h123453);
        push_item(aafc_pkg::OP_CORRECT, 24'h123452);   // two addresses one bit away
        push_item(aafc_pkg::OP_CORRECT, 24'h123466);   // unique, two bits
        push_item(aafc_pkg::OP_CORRECT, 24'h123356);   // three bits, over the limit
        push_item(aafc_pkg::OP_TEST,    24'hABCDEF);
        push_item(aafc_pkg::OP_EXPIRE,  24'h000000);
        push_item(aafc_pkg::OP_ADD,     24'hABCDEF);
        push_item(aafc_pkg::OP_TEST,    24'h123456);   // still in the older table
        push_item(aafc_pkg::OP_CORRECT, 24'hFFFFFD);   // match from the older table
        push_item(aafc_pkg::OP_EXPIRE,  24'hFFFFFF);
        push_item(aafc_pkg::OP_TEST,    24'h123456);   // aged out
        push_item(aafc_pkg::OP_TEST,    24'hABCDEF);
        push_item(aafc_pkg::OP_ADD,     24'h800000);
        push_item(aafc_pkg::OP_ADD,     24'h7FFFFF);
        wait_all_done();

        // Limit of 24, the widest address distance
        set_limit(5'd24);
        push_item(aafc_pkg::OP_CORRECT, 24'h000000);
        push_item(aafc_pkg::OP_CORRECT, 24'hFFFFFF);
        push_item(aafc_pkg::OP_CORRECT, 24'h555555);
        push_item(aafc_pkg::OP_CORRECT, 24'hAAAAAA);
        wait_all_done();

        // Load the active table with distinct addresses; limit zero
        set_limit(5'd0);
        send_idle_pct <= 5;
        recv_idle_pct <= 5;
        push_item(aafc_pkg::OP_EXPIRE, 24'h000000);
        push_item(aafc_pkg::OP_EXPIRE, 24'h000000);
        while (fill_addrs.size() < FILL_N)
        begin
            a = 24'($urandom());
            if (!fill_taken.exists(a))
            begin
                fill_taken[a] = 1'b1;
                fill_addrs.push_back(a);
                push_item(aafc_pkg::OP_ADD, a);
            end
        end
        push_item(aafc_pkg::OP_ADD,     fill_addrs[5]);    // already present
        push_item(aafc_pkg::OP_TEST,    fill_addrs[FILL_N - 3]);
        push_item(aafc_pkg::OP_CORRECT, fill_addrs[10]);
        push_item(aafc_pkg::OP_CORRECT, flip_bits(fill_addrs[11], 1));
        wait_all_done();

        set_limit(5'd24);
        push_item(aafc_pkg::OP_CORRECT, flip_bits(fill_addrs[20], 1));
        push_item(aafc_pkg::OP_CORRECT, 24'($urandom()));
        push_item(aafc_pkg::OP_EXPIRE,  24'h000000);
        push_item(aafc_pkg::OP_TEST,    fill_addrs[0]);
        push_item(aafc_pkg::OP_CORRECT, flip_bits(fill_addrs[1], 1));
        push_item(aafc_pkg::OP_EXPIRE,  24'h000000);
        wait_all_done();

        // Random phases over several limits
        set_limit(5'd1);
        send_idle_pct <= 30;
        recv_idle_pct <= 30;
        queue_random_items(40);
        wait_all_done();

        set_limit(5'd3);
        send_idle_pct <= 10;
        recv_idle_pct <= 50;
        queue_random_items(40);
        @(posedge clk);
        hold_arm <= 1'b1;
        wait_all_done();

        set_limit(5'd31);
        send_idle_pct <= 50;
        recv_idle_pct <= 10;
        queue_random_items(30);
        wait_all_done();

        set_limit(5'($urandom_range(0, 31)));
        send_idle_pct <= 15;
        recv_idle_pct <= 15;
        queue_random_items(30);
        wait_all_done();

        set_limit(5'd24);
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        queue_random_items(30);
        wait_all_done();

        // Quiet tail
        set_limit(aafc_pkg::MAX_BITS_RST);
        queue_random_items(40);
        wait_all_done();
        repeat (50) @(negedge clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #300_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
